/* hw/rtl/dll_pkg.sv */
package dll_pkg;

	// pool size and derived widths
	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int LEN_W    = 6;

	// request kinds
	typedef enum logic [2:0] {
		REQ_PUSH_FRONT    = 3'd0,
		REQ_PUSH_BACK     = 3'd1,
		REQ_INSERT_BEFORE = 3'd2,
		REQ_INSERT_AFTER  = 3'd3,
		REQ_POP_FRONT     = 3'd4,
		REQ_POP_BACK      = 3'd5
	} req_kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// what the travelling token does at the cell it reaches
	typedef enum logic [2:0] {
		MODE_DONE          = 3'd0,
		MODE_SEARCH_BEFORE = 3'd1,
		MODE_SEARCH_AFTER  = 3'd2,
		MODE_INSERT        = 3'd3,
		MODE_APPEND        = 3'd4,
		MODE_POP_HEAD      = 3'd5,
		MODE_SHIFT         = 3'd6,
		MODE_POP_TAIL      = 3'd7
	} mode_t;

	// request payload
	typedef struct packed {
		logic [2:0]              req_type;
		logic signed [VAL_W-1:0] new_value;
		logic signed [VAL_W-1:0] match_value;
	} req_t;

	// result payload
	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] removed_value;
		logic [LEN_W-1:0]        length;
	} rsp_t;

	// token handed from cell to cell
	typedef struct packed {
		logic             active;
		mode_t            mode;
		logic             full;
		status_t          status;
		logic [VAL_W-1:0] data;
		logic [VAL_W-1:0] match;
	} token_t;

	// what a cell shows to the cell in front of it
	typedef struct packed {
		logic             used;
		logic [VAL_W-1:0] value;
	} view_t;

endpackage

/* hw/rtl/dll_cell.sv */
module dll_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  dll_pkg::token_t tok_in,
	output dll_pkg::token_t tok_out,
	input  dll_pkg::view_t  nbr_in,
	output dll_pkg::view_t  self_out
);

	logic                      used_q;
	logic                      used_nx;
	logic [dll_pkg::VAL_W-1:0] val_q;
	logic [dll_pkg::VAL_W-1:0] val_nx;
	logic                      act_q;
	dll_pkg::token_t           pay_q;
	dll_pkg::token_t           tok_nx;

	// action of this cell when the token arrives
	always_comb begin
		tok_nx  = tok_in;
		val_nx  = val_q;
		used_nx = used_q;
		if (tok_in.active) begin
			unique case (tok_in.mode) inside
				dll_pkg::MODE_DONE: begin
				end
				dll_pkg::MODE_SEARCH_BEFORE, dll_pkg::MODE_SEARCH_AFTER: begin
					if (!used_q) begin
						tok_nx.mode   = dll_pkg::MODE_DONE;
						tok_nx.status = dll_pkg::ST_NOT_FOUND;
					end else if (val_q == tok_in.match) begin
						if (tok_in.full) begin
							tok_nx.mode   = dll_pkg::MODE_DONE;
							tok_nx.status = dll_pkg::ST_FULL;
						end else if (tok_in.mode == dll_pkg::MODE_SEARCH_BEFORE) begin
							// new value takes this place, old one ripples on
							val_nx      = tok_in.data;
							tok_nx.data = val_q;
							tok_nx.mode = dll_pkg::MODE_INSERT;
						end else begin
							tok_nx.mode = dll_pkg::MODE_INSERT;
						end
					end
				end
				dll_pkg::MODE_INSERT: begin
					val_nx      = tok_in.data;
					tok_nx.data = val_q;
					if (!used_q) begin
						used_nx       = 1'b1;
						tok_nx.mode   = dll_pkg::MODE_DONE;
						tok_nx.status = dll_pkg::ST_OK;
					end
				end
				dll_pkg::MODE_APPEND: begin
					if (!used_q) begin
						val_nx        = tok_in.data;
						used_nx       = 1'b1;
						tok_nx.mode   = dll_pkg::MODE_DONE;
						tok_nx.status = dll_pkg::ST_OK;
					end
				end
				dll_pkg::MODE_POP_HEAD, dll_pkg::MODE_SHIFT: begin
					// head value leaves with the token, the rest moves forward
					if (tok_in.mode == dll_pkg::MODE_POP_HEAD) begin
						tok_nx.data = val_q;
					end
					if (nbr_in.used) begin
						val_nx      = nbr_in.value;
						tok_nx.mode = dll_pkg::MODE_SHIFT;
					end else begin
						used_nx       = 1'b0;
						tok_nx.mode   = dll_pkg::MODE_DONE;
						tok_nx.status = dll_pkg::ST_OK;
					end
				end
				dll_pkg::MODE_POP_TAIL: begin
					if (!nbr_in.used) begin
						tok_nx.data   = val_q;
						used_nx       = 1'b0;
						tok_nx.mode   = dll_pkg::MODE_DONE;
						tok_nx.status = dll_pkg::ST_OK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// occupancy and token presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else begin
			used_q <= used_nx;
			act_q  <= tok_in.active;
		end
	end

	// stored value and token payload
	always_ff @(posedge clk) begin
		val_q <= val_nx;
		pay_q <= tok_nx;
	end

	// outputs to the neighbours
	always_comb begin
		tok_out        = pay_q;
		tok_out.active = act_q;
		self_out.used  = used_q;
		self_out.value = val_q;
	end

endmodule

/* hw/rtl/doubly_linked_list_engine.sv */
// Ordered list of up to dll_pkg::CAPACITY signed 32-bit values, kept in list order in a row
// of cells. A request is taken when start is high and busy is low; it then travels
// down the row one cell per clock, so every request, whatever its kind, walks the
// whole row and gives its result with a one-cycle done strobe, and busy is low
// again in that strobe cycle. No new request is taken while one is in the row.
// The result cannot be held off, so it must be taken in the strobe cycle. No
// clearing pass follows reset; the engine is ready at once.
module doubly_linked_list_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dll_pkg::req_t req,
	output logic          done,
	output dll_pkg::rsp_t rsp
);

	logic                      busy_q;
	logic                      done_q;
	dll_pkg::rsp_t             rsp_q;
	logic [dll_pkg::CNT_W-1:0] count_q;
	logic [dll_pkg::CNT_W-1:0] count_nx;
	logic [2:0]                op_q;
	logic                      launch_act_q;
	dll_pkg::token_t           launch_q;
	dll_pkg::token_t           launch_nx;
	logic                      accept;
	logic                      full;
	logic                      empty;
	logic                      finish;
	dll_pkg::status_t          fin_status;
	logic [dll_pkg::VAL_W-1:0] fin_removed;
	dll_pkg::token_t           tok_chain [dll_pkg::CAPACITY+1];
	dll_pkg::view_t            view      [dll_pkg::CAPACITY+1];

	assign accept = start && !busy_q;
	assign full   = (count_q == dll_pkg::CNT_W'(dll_pkg::CAPACITY));
	assign empty  = (count_q == '0);
	assign finish = tok_chain[dll_pkg::CAPACITY].active;

	// request decode into the first token
	always_comb begin
		launch_nx.active = 1'b1;
		launch_nx.full   = full;
		launch_nx.status = dll_pkg::ST_OK;
		launch_nx.data   = req.new_value;
		launch_nx.match  = req.match_value;
		launch_nx.mode   = dll_pkg::MODE_DONE;
		unique case (req.req_type) inside
			dll_pkg::REQ_PUSH_FRONT, dll_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					launch_nx.status = dll_pkg::ST_FULL;
				end else if (req.req_type == dll_pkg::REQ_PUSH_FRONT) begin
					launch_nx.mode = dll_pkg::MODE_INSERT;
				end else begin
					launch_nx.mode = dll_pkg::MODE_APPEND;
				end
			end
			dll_pkg::REQ_INSERT_BEFORE, dll_pkg::REQ_INSERT_AFTER: begin
				if (empty) begin
					launch_nx.status = dll_pkg::ST_EMPTY;
				end else if (req.req_type == dll_pkg::REQ_INSERT_BEFORE) begin
					launch_nx.mode = dll_pkg::MODE_SEARCH_BEFORE;
				end else begin
					launch_nx.mode = dll_pkg::MODE_SEARCH_AFTER;
				end
			end
			dll_pkg::REQ_POP_FRONT, dll_pkg::REQ_POP_BACK: begin
				if (empty) begin
					launch_nx.status = dll_pkg::ST_EMPTY;
				end else if (req.req_type == dll_pkg::REQ_POP_FRONT) begin
					launch_nx.mode = dll_pkg::MODE_POP_HEAD;
				end else begin
					launch_nx.mode = dll_pkg::MODE_POP_TAIL;
				end
			end
			default: begin
			end
		endcase
	end

	// token entering the row
	always_comb begin
		tok_chain[0]        = launch_q;
		tok_chain[0].active = launch_act_q;
	end

	// the end of the row sees an empty neighbour
	assign view[dll_pkg::CAPACITY] = '{used: 1'b0, value: '0};

	// row of cells
	for (genvar k = 0; k < dll_pkg::CAPACITY; k++) begin : g_cell
		dll_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_chain[k]),
			.tok_out  (tok_chain[k+1]),
			.nbr_in   (view[k+1]),
			.self_out (view[k])
		);
	end

	// result from the token leaving the row
	always_comb begin
		fin_status  = tok_chain[dll_pkg::CAPACITY].status;
		fin_removed = '0;
		count_nx    = count_q;
		// a search that ran off the end found nothing
		if (tok_chain[dll_pkg::CAPACITY].mode != dll_pkg::MODE_DONE) begin
			fin_status = dll_pkg::ST_NOT_FOUND;
		end
		if (fin_status == dll_pkg::ST_OK) begin
			unique case (op_q) inside
				dll_pkg::REQ_PUSH_FRONT, dll_pkg::REQ_PUSH_BACK,
				dll_pkg::REQ_INSERT_BEFORE, dll_pkg::REQ_INSERT_AFTER: begin
					count_nx = count_q + 1'b1;
				end
				dll_pkg::REQ_POP_FRONT, dll_pkg::REQ_POP_BACK: begin
					count_nx    = count_q - 1'b1;
					fin_removed = tok_chain[dll_pkg::CAPACITY].data;
				end
				default: begin
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			launch_act_q <= 1'b0;
			count_q      <= '0;
		end else begin
			launch_act_q <= accept;
			done_q       <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				count_q <= count_nx;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			launch_q <= launch_nx;
			op_q     <= req.req_type;
		end
		if (finish) begin
			rsp_q.status        <= fin_status;
			rsp_q.removed_value <= fin_removed;
			rsp_q.length        <= dll_pkg::LEN_W'(count_nx);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// element count stays within the pool
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dll_pkg::CNT_W'(dll_pkg::CAPACITY))
		else $error("element count above pool size");

	// a token only leaves the row while a request is in flight
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> busy_q)
		else $error("token left the row with no request in flight");

	// a result strobe follows the token leaving the row and frees the engine
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> done_q && !busy_q)
		else $error("result strobe or busy release missing");

	// count only changes when a result is formed
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!finish |=> $stable(count_q))
		else $error("element count changed outside a result");

endmodule

/* bench/doubly_linked_list_engine_tb.sv */
`timescale 1ns / 100ps

module doubly_linked_list_engine_tb;

	// request codes with no operation behind them
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 1100;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	dll_pkg::req_t req = '0;
	dll_pkg::rsp_t rsp;

	// list contents as seen from the outside, front first
	logic signed [dll_pkg::VAL_W-1:0] shadow_list[$];
	dll_pkg::req_t req_backlog[$];
	dll_pkg::rsp_t rsp_due[$];
	dll_pkg::rsp_t want;

	int total_items = 1;
	int taken_cnt = 0;
	int handed_cnt = 0;
	int gap_left = 0;
	bit drop_now;
	int errors = 0;
	int cnt_ok = 0, cnt_empty = 0, cnt_missing = 0, cnt_full = 0, cnt_popped = 0;

	doubly_linked_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// apply one request to the shadow list and give the result it should produce
	function automatic dll_pkg::rsp_t list_apply(dll_pkg::req_t r);
		dll_pkg::rsp_t res;
		int pos;
		res = '0;
		res.status = dll_pkg::ST_OK;
		pos = -1;
		case (r.req_type)
			dll_pkg::REQ_PUSH_FRONT: begin
				if (shadow_list.size() >= dll_pkg::CAPACITY)
					res.status = dll_pkg::ST_FULL;
				else
					shadow_list.push_front(r.new_value);
			end
			dll_pkg::REQ_PUSH_BACK: begin
				if (shadow_list.size() >= dll_pkg::CAPACITY)
					res.status = dll_pkg::ST_FULL;
				else
					shadow_list.push_back(r.new_value);
			end
			dll_pkg::REQ_INSERT_BEFORE, dll_pkg::REQ_INSERT_AFTER: begin
				if (shadow_list.size() == 0) begin
					res.status = dll_pkg::ST_EMPTY;
				end else begin
					// first match from the front wins
					for (int i = 0; i < shadow_list.size(); i++)
						if (pos < 0 && shadow_list[i] == r.match_value)
							pos = i;
					if (pos < 0)
						res.status = dll_pkg::ST_NOT_FOUND;
					else if (shadow_list.size() >= dll_pkg::CAPACITY)
						res.status = dll_pkg::ST_FULL;
					else if (r.req_type == dll_pkg::REQ_INSERT_AFTER)
						shadow_list.insert(pos + 1, r.new_value);
					else
						shadow_list.insert(pos, r.new_value);
				end
			end
			dll_pkg::REQ_POP_FRONT: begin
				if (shadow_list.size() == 0)
					res.status = dll_pkg::ST_EMPTY;
				else
					res.removed_value = shadow_list.pop_front();
			end
			dll_pkg::REQ_POP_BACK: begin
				if (shadow_list.size() == 0)
					res.status = dll_pkg::ST_EMPTY;
				else
					res.removed_value = shadow_list.pop_back();
			end
			default: ;
		endcase
		res.length = dll_pkg::LEN_W'(shadow_list.size());
		return res;
	endfunction

	// values drawn mostly from a small set so that references hit and repeat
	function automatic logic signed [dll_pkg::VAL_W-1:0] pick_value();
		logic signed [dll_pkg::VAL_W-1:0] v;
		case ($urandom_range(0, 11))
			0: v = 32'sd0;
			1: v = 32'sd1;
			2: v = -32'sd1;
			3: v = 32'sh8000_0000;
			4: v = 32'sh7fff_ffff;
			5: v = 32'sd7;
			6: v = -32'sd7;
			7: v = 32'sh0000_0100;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// share of cycles in which the sender holds back, by phase of the run
	function automatic int idle_share();
		case ((taken_cnt * 4) / total_items)
			1: return 55;
			3: return 33;
			default: return 0;
		endcase
	endfunction

	task automatic add_req(logic [2:0] kind, logic signed [dll_pkg::VAL_W-1:0] nv,
			logic signed [dll_pkg::VAL_W-1:0] mv);
		dll_pkg::req_t r;
		r.req_type = kind;
		r.new_value = nv;
		r.match_value = mv;
		req_backlog.push_back(r);
	endtask

	task automatic note_mismatch(string what, dll_pkg::rsp_t exp_rsp, dll_pkg::rsp_t got_rsp);
		errors++;
		if (errors <= 10)
			$display({"%0t %s: expected status %0d removed %0d length %0d,",
				" got status %0d removed %0d length %0d"},
				$realtime, what, exp_rsp.status, exp_rsp.removed_value, exp_rsp.length,
				got_rsp.status, got_rsp.removed_value, got_rsp.length);
	endtask

	// driver: present the oldest pending request until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (taken_cnt != handed_cnt) begin
				void'(req_backlog.pop_front());
				handed_cnt++;
				if ($urandom_range(0, 99) < idle_share())
					gap_left = $urandom_range(1, 40);
			end
			if (gap_left > 0)
				gap_left--;
			drop_now = $urandom_range(0, 99) < idle_share();
			if (req_backlog.size() != 0 && gap_left == 0 && !drop_now) begin
				start <= 1'b1;
				req <= req_backlog[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check each result, then predict any request taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					note_mismatch("result with no request pending", '0, rsp);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.status
							|| rsp.removed_value !== want.removed_value
							|| rsp.length !== want.length)
						note_mismatch("result mismatch", want, rsp);
					case (want.status)
						dll_pkg::ST_OK: cnt_ok++;
						dll_pkg::ST_EMPTY: cnt_empty++;
						dll_pkg::ST_NOT_FOUND: cnt_missing++;
						default: cnt_full++;
					endcase
					if (want.status == dll_pkg::ST_OK && want.removed_value != 0)
						cnt_popped++;
				end
			end
			if (start && !busy) begin
				rsp_due.push_back(list_apply(req));
				taken_cnt++;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int mode;
		int roll;
		logic [2:0] kind;

		// directed: empty list cases, extremes, both ends, duplicates, spare codes
		add_req(dll_pkg::REQ_POP_FRONT, 32'sd0, 32'sd0);
		add_req(dll_pkg::REQ_POP_BACK, 32'sd0, 32'sd0);
		add_req(dll_pkg::REQ_INSERT_BEFORE, 32'sd5, 32'sd0);
		add_req(dll_pkg::REQ_INSERT_AFTER, 32'sd5, 32'sd0);
		add_req(dll_pkg::REQ_PUSH_FRONT, 32'sh8000_0000, 32'sh7fff_ffff);
		add_req(dll_pkg::REQ_PUSH_BACK, 32'sh7fff_ffff, 32'sh8000_0000);
		add_req(dll_pkg::REQ_PUSH_FRONT, 32'sd0, -32'sd1);
		add_req(dll_pkg::REQ_PUSH_BACK, -32'sd1, 32'sd0);
		add_req(dll_pkg::REQ_INSERT_BEFORE, 32'sd11, 32'sd0);
		add_req(dll_pkg::REQ_INSERT_AFTER, 32'sd12, -32'sd1);
		add_req(dll_pkg::REQ_INSERT_BEFORE, 32'sd11, 32'sh8000_0000);
		add_req(dll_pkg::REQ_INSERT_AFTER, 32'sd13, 32'sd11);
		add_req(dll_pkg::REQ_INSERT_BEFORE, 32'sd14, 32'sd123);
		add_req(REQ_SPARE_LO, 32'sd1, 32'sd1);
		add_req(REQ_SPARE_HI, -32'sd1, -32'sd1);
		for (int i = 0; i < 9; i++)
			add_req((i % 2) ? dll_pkg::REQ_POP_BACK : dll_pkg::REQ_POP_FRONT,
				$urandom, $urandom);
		add_req(dll_pkg::REQ_POP_BACK, 32'sd0, 32'sd0);

		// random: fill-heavy, drain-heavy and mixed stretches of a hundred
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = (i / 100) % 3;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				kind = 3'($urandom_range(6, 7));
			else if (roll < ((mode == 0) ? 85 : (mode == 1) ? 25 : 55))
				kind = 3'($urandom_range(0, 3));
			else
				kind = 3'($urandom_range(4, 5));
			add_req(kind, pick_value(), pick_value());
		end
		total_items = req_backlog.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (taken_cnt == total_items && rsp_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += rsp_due.size();

		$display("ran %0d requests: %0d ok (%0d pops with a nonzero value), %0d empty,",
			taken_cnt, cnt_ok, cnt_popped, cnt_empty);
		$display("%0d reference missing, %0d pool full", cnt_missing, cnt_full);
		if (errors == 0)
			$display("doubly_linked_list_engine: match");
		else
			$display("doubly_linked_list_engine: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("timeout with %0d of %0d requests taken", taken_cnt, total_items);
		$display("doubly_linked_list_engine: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/dll_pkg.sv
hw/rtl/dll_cell.sv
hw/rtl/doubly_linked_list_engine.sv
bench/doubly_linked_list_engine_tb.sv
